>>> design/mvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants for the 4x4 matrix-vector transform
// Operation codes, element geometry and the request record that moves along
// the cell chain.
// ----------------------------------------------------------------------------
package mvt_pkg;

   localparam int N_CELLS       = 4;
   localparam int ELEM_W        = 32;
   localparam int OP_W          = 2;
   localparam int IDX_W         = 2;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [OP_W-1:0] OP_WRITE     = 2'd0;
   localparam logic [OP_W-1:0] OP_TRANSPOSE = 2'd1;
   localparam logic [OP_W-1:0] OP_MAT_VEC   = 2'd2;
   localparam logic [OP_W-1:0] OP_VEC_MAT   = 2'd3;

   typedef struct packed {
      logic                             valid;
      logic [OP_W-1:0]                  op;
      logic [IDX_W-1:0]                 row;
      logic [IDX_W-1:0]                 col;
      logic [ELEM_W-1:0]                value;
      logic [N_CELLS-1:0][ELEM_W-1:0]   vec;
   } req_type;

endpackage

>>> design/mvt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_cell: one cell of the transform chain
// Holds row K and column K of the matrix, applies writes and transposes as a
// request passes, forms its four products with vector component K and adds the previous cell's products into the sums.
// ----------------------------------------------------------------------------
module mvt_cell #(
   parameter int CELL_INDEX = 0,
   parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF,
   localparam int PROD_W    = 2 * mvt_pkg::ELEM_W - FRAC_BITS,
   localparam int SUM_W     = PROD_W + 2
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  mvt_pkg::req_type                       up_req,
   input  logic [mvt_pkg::N_CELLS-1:0][SUM_W-1:0]  up_acc,
   input  logic [mvt_pkg::N_CELLS-1:0][PROD_W-1:0] up_prod,
   output mvt_pkg::req_type                       dn_req,
   output logic [mvt_pkg::N_CELLS-1:0][SUM_W-1:0]  dn_acc,
   output logic [mvt_pkg::N_CELLS-1:0][PROD_W-1:0] dn_prod
);

   localparam int N  = mvt_pkg::N_CELLS;
   localparam int EW = mvt_pkg::ELEM_W;
   localparam logic [mvt_pkg::IDX_W-1:0] MY_IDX = mvt_pkg::IDX_W'(CELL_INDEX);

   logic [N-1:0][EW-1:0]     col_ff, col_in;   // M[i][K]
   logic [N-1:0][EW-1:0]     row_ff, row_in;   // M[K][i]
   logic [N-1:0][EW-1:0]     line;
   logic [N-1:0][2*EW-1:0]   full;
   logic [N-1:0][PROD_W-1:0] prod_in, prod_ff;
   logic [N-1:0][SUM_W-1:0]  acc_in, acc_ff;
   mvt_pkg::req_type         req_ff;

   always_comb begin
      line = (up_req.op == mvt_pkg::OP_MAT_VEC) ? col_ff : row_ff;
      for (int i = 0; i < N; i++) begin
         full[i]    = $signed(line[i]) * $signed(up_req.vec[CELL_INDEX]);
         // truncation toward minus infinity
         prod_in[i] = full[i][2*EW-1:FRAC_BITS];
         acc_in[i]  = up_acc[i] + {{2{up_prod[i][PROD_W-1]}}, up_prod[i]};
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (up_req.valid) begin
         unique case (up_req.op)
            mvt_pkg::OP_WRITE: begin
               if (up_req.col == MY_IDX) col_in[up_req.row] = up_req.value;
               if (up_req.row == MY_IDX) row_in[up_req.col] = up_req.value;
            end
            mvt_pkg::OP_TRANSPOSE: begin
               col_in = row_ff;
               row_in = col_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         req_ff.valid <= 1'b0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
         req_ff <= up_req;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff  <= acc_in;
         prod_ff <= prod_in;
      end
   end

   assign dn_req  = req_ff;
   assign dn_acc  = acc_ff;
   assign dn_prod = prod_ff;

endmodule

>>> design/mvt_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_out: final sum, saturation and result register
// Adds the last cell's products, clamps each component to 32 bits and holds
// the result until it is taken.
// ----------------------------------------------------------------------------
module mvt_out #(
   parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF,
   localparam int PROD_W    = 2 * mvt_pkg::ELEM_W - FRAC_BITS,
   localparam int SUM_W     = PROD_W + 2
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load,
   input  logic [mvt_pkg::N_CELLS-1:0][SUM_W-1:0]         acc,
   input  logic [mvt_pkg::N_CELLS-1:0][PROD_W-1:0]        prod,
   input  logic                                          rsp_ready,
   output logic                                          rsp_valid,
   output logic [mvt_pkg::N_CELLS-1:0][mvt_pkg::ELEM_W-1:0] rsp_res,
   output logic                                          rsp_overflow
);

   localparam int N  = mvt_pkg::N_CELLS;
   localparam int EW = mvt_pkg::ELEM_W;
   localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-EW){1'b0}}, 1'b0, {(EW-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-EW){1'b1}}, 1'b1, {(EW-1){1'b0}}};

   logic [N-1:0][SUM_W-1:0] total;
   logic [N-1:0][EW-1:0]    res_in, res_ff;
   logic [N-1:0]            sat;
   logic                    valid_ff, ovf_ff;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         total[i] = acc[i] + {{2{prod[i][PROD_W-1]}}, prod[i]};
         if ($signed(total[i]) > SAT_HI) begin
            res_in[i] = SAT_HI[EW-1:0];
            sat[i]    = 1'b1;
         end else if ($signed(total[i]) < SAT_LO) begin
            res_in[i] = SAT_LO[EW-1:0];
            sat[i]    = 1'b1;
         end else begin
            res_in[i] = total[i][EW-1:0];
            sat[i]    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
         ovf_ff <= |sat;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_res      = res_ff;
   assign rsp_overflow = ovf_ff;

endmodule

>>> design/matrix4x4_vector_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4x4_vector_transform: 4x4 Q16.16 matrix store with M*v and v*M
// Top level: chain of four cells plus the saturating result register.
// ----------------------------------------------------------------------------
// Takes one request per cycle while req_ready is high. Every request walks a
// chain of four cells, one cell per cycle while the chain advances; cell K
// keeps row K and column K of the matrix, so element writes and transposes
// land in each cell in request order and a later transform sees them. Cell K
// multiplies vector component K by its four matrix entries, the products are
// accumulated down the chain, and a final stage saturates and registers the
// result. Writes and transposes give no response. req_ready drops only when a
// finished transform sits at the end of the chain while the result register
// is still full and rsp_ready is low. The matrix is zero after reset.
module matrix4x4_vector_transform #(
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mvt_pkg::OP_W-1:0]           req_operation,
   input  logic [mvt_pkg::IDX_W-1:0]          req_row,
   input  logic [mvt_pkg::IDX_W-1:0]          req_col,
   input  logic signed [mvt_pkg::ELEM_W-1:0]  req_value,
   input  logic signed [mvt_pkg::ELEM_W-1:0]  req_vec_x,
   input  logic signed [mvt_pkg::ELEM_W-1:0]  req_vec_y,
   input  logic signed [mvt_pkg::ELEM_W-1:0]  req_vec_z,
   input  logic signed [mvt_pkg::ELEM_W-1:0]  req_vec_w,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [mvt_pkg::ELEM_W-1:0]  rsp_res_x,
   output logic signed [mvt_pkg::ELEM_W-1:0]  rsp_res_y,
   output logic signed [mvt_pkg::ELEM_W-1:0]  rsp_res_z,
   output logic signed [mvt_pkg::ELEM_W-1:0]  rsp_res_w,
   output logic                               rsp_overflow
);

   localparam int N      = mvt_pkg::N_CELLS;
   localparam int EW     = mvt_pkg::ELEM_W;
   localparam int PROD_W = 2 * EW - FRAC_BITS;
   localparam int SUM_W  = PROD_W + 2;

   mvt_pkg::req_type        req_chain  [N+1];
   logic [N-1:0][SUM_W-1:0]  acc_chain  [N+1];
   logic [N-1:0][PROD_W-1:0] prod_chain [N+1];
   logic [N-1:0][EW-1:0]     rsp_res;
   logic                     advance;
   logic                     tail_result;
   logic                     load;

   always_comb begin
      req_chain[0].valid  = req_valid;
      req_chain[0].op     = req_operation;
      req_chain[0].row    = req_row;
      req_chain[0].col    = req_col;
      req_chain[0].value  = req_value;
      req_chain[0].vec[0] = req_vec_x;
      req_chain[0].vec[1] = req_vec_y;
      req_chain[0].vec[2] = req_vec_z;
      req_chain[0].vec[3] = req_vec_w;
   end

   assign acc_chain[0]  = '0;
   assign prod_chain[0] = '0;

   generate
      for (genvar k = 0; k < N; k++) begin : g_cell
         mvt_cell #(
            .CELL_INDEX (k),
            .FRAC_BITS  (FRAC_BITS)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .up_req  (req_chain[k]),
            .up_acc  (acc_chain[k]),
            .up_prod (prod_chain[k]),
            .dn_req  (req_chain[k+1]),
            .dn_acc  (acc_chain[k+1]),
            .dn_prod (prod_chain[k+1])
         );
      end
   endgenerate

   assign tail_result = req_chain[N].valid &&
                        (req_chain[N].op == mvt_pkg::OP_MAT_VEC ||
                         req_chain[N].op == mvt_pkg::OP_VEC_MAT);
   // the chain only holds when a result has nowhere to go
   assign advance   = !(tail_result && rsp_valid && !rsp_ready);
   assign load      = advance && tail_result;
   assign req_ready = advance;

   mvt_out #(
      .FRAC_BITS (FRAC_BITS)
   ) u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .acc          (acc_chain[N]),
      .prod         (prod_chain[N]),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_res      (rsp_res),
      .rsp_overflow (rsp_overflow)
   );

   assign rsp_res_x = rsp_res[0];
   assign rsp_res_y = rsp_res[1];
   assign rsp_res_z = rsp_res[2];
   assign rsp_res_w = rsp_res[3];

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   a_accept_enters_chain : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> req_chain[1].valid)
      else $error("accepted request missing from first cell");

   a_tail_to_result : assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("transform left the chain without a response");

   a_overflow_saturated : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         (rsp_res_x == 32'sh7fff_ffff || rsp_res_x == 32'sh8000_0000 ||
          rsp_res_y == 32'sh7fff_ffff || rsp_res_y == 32'sh8000_0000 ||
          rsp_res_z == 32'sh7fff_ffff || rsp_res_z == 32'sh8000_0000 ||
          rsp_res_w == 32'sh7fff_ffff || rsp_res_w == 32'sh8000_0000))
      else $error("overflow flagged without a clamped component");

endmodule

>>> sim/tb_matrix4x4_vector_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix4x4_vector_transform: self-checking bench for the 4x4 transform
// Walks a short table of directed requests, then about 600 random ones, with
// random idle cycles on both channels. A shadow matrix predicts each M*v and v*M
// response not given by hand in the table; all responses are checked in order.
// ----------------------------------------------------------------------------
module tb_matrix4x4_vector_transform;

   typedef logic signed [mvt_pkg::ELEM_W-1:0] q16_type;

   typedef struct {
      q16_type res [mvt_pkg::N_CELLS];
      logic    overflow;
   } transform_result_type;

   typedef struct {
      logic [mvt_pkg::OP_W-1:0]  op;
      logic [mvt_pkg::IDX_W-1:0] row;
      logic [mvt_pkg::IDX_W-1:0] col;
      q16_type                   value;
      q16_type                   vec [mvt_pkg::N_CELLS];
      bit                        typed;     // response given by hand in the table
      transform_result_type      want;
   } stim_row_type;

   localparam q16_type Q_MAX = 32'sh7FFF_FFFF;
   localparam q16_type Q_MIN = 32'sh8000_0000;
   localparam q16_type ONE   = 32'sh0001_0000;
   localparam q16_type HALF  = 32'sh0000_8000;
   localparam longint  SAT_HI = 64'sd2147483647;
   localparam longint  SAT_LO = -64'sd2147483648;

   localparam int RANDOM_ITEMS    = 600;
   localparam int PAUSE_AT        = 300;
   localparam int HOLD_OFF_AT     = 60;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int TAIL_CYCLES     = 12;
   localparam int WATCHDOG_LIMIT  = 1000;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready;
   logic [mvt_pkg::OP_W-1:0] req_operation;
   logic [mvt_pkg::IDX_W-1:0] req_row, req_col;
   q16_type req_value, req_vec_x, req_vec_y, req_vec_z, req_vec_w;
   logic rsp_valid, rsp_ready;
   q16_type rsp_res_x, rsp_res_y, rsp_res_z, rsp_res_w;
   logic rsp_overflow;

   q16_type              shadow_matrix [16];
   transform_result_type pending_transforms [$];
   stim_row_type         directed_rows [$];

   int error_count = 0;
   int results_seen = 0;
   int n_writes = 0, n_transposes = 0, n_transforms = 0, n_saturated = 0;
   int idle_cycles = 0;

   matrix4x4_vector_transform uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .req_vec_x     (req_vec_x),
      .req_vec_y     (req_vec_y),
      .req_vec_z     (req_vec_z),
      .req_vec_w     (req_vec_w),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_res_x     (rsp_res_x),
      .rsp_res_y     (rsp_res_y),
      .rsp_res_z     (rsp_res_z),
      .rsp_res_w     (rsp_res_w),
      .rsp_overflow  (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Products are exact in 64 bits, floored by the fraction shift, summed
   // without loss and then clamped to 32 bits.
   function automatic transform_result_type predict_transform(
         input logic [mvt_pkg::OP_W-1:0] op,
         input q16_type v [mvt_pkg::N_CELLS]);
      transform_result_type r;
      longint acc;
      q16_type elem;
      int i, j;
      r.overflow = 1'b0;
      for (i = 0; i < mvt_pkg::N_CELLS; i++) begin
         acc = 0;
         for (j = 0; j < mvt_pkg::N_CELLS; j++) begin
            elem = (op == mvt_pkg::OP_MAT_VEC) ? shadow_matrix[i*4+j] : shadow_matrix[j*4+i];
            acc += (longint'(elem) * longint'(v[j])) >>> mvt_pkg::FRAC_BITS_DEF;
         end
         if (acc > SAT_HI) begin
            r.res[i] = Q_MAX;
            r.overflow = 1'b1;
         end else if (acc < SAT_LO) begin
            r.res[i] = Q_MIN;
            r.overflow = 1'b1;
         end else begin
            r.res[i] = q16_type'(acc);
         end
      end
      return r;
   endfunction

   // Update the shadow matrix for one accepted request, or queue a transform's response.
   function automatic void apply_request(input stim_row_type s);
      q16_type t;
      int i, j;
      case (s.op)
         mvt_pkg::OP_WRITE: begin
            shadow_matrix[s.row*4+s.col] = s.value;
            n_writes++;
         end
         mvt_pkg::OP_TRANSPOSE: begin
            for (i = 0; i < mvt_pkg::N_CELLS; i++)
               for (j = i + 1; j < mvt_pkg::N_CELLS; j++) begin
                  t = shadow_matrix[i*4+j];
                  shadow_matrix[i*4+j] = shadow_matrix[j*4+i];
                  shadow_matrix[j*4+i] = t;
               end
            n_transposes++;
         end
         default: begin
            if (s.typed)
               pending_transforms.push_back(s.want);
            else
               pending_transforms.push_back(predict_transform(s.op, s.vec));
            n_transforms++;
         end
      endcase
   endfunction

   function automatic void add_row(input logic [mvt_pkg::OP_W-1:0] op,
                                   input logic [mvt_pkg::IDX_W-1:0] row,
                                   input logic [mvt_pkg::IDX_W-1:0] col, input q16_type value,
                                   input q16_type x, input q16_type y, input q16_type z,
                                   input q16_type w);
      stim_row_type s;
      s.op = op;
      s.row = row;
      s.col = col;
      s.value = value;
      s.vec[0] = x;
      s.vec[1] = y;
      s.vec[2] = z;
      s.vec[3] = w;
      s.typed = 1'b0;
      directed_rows.push_back(s);
   endfunction

   function automatic void add_typed(input logic [mvt_pkg::OP_W-1:0] op, input q16_type x,
                                     input q16_type y, input q16_type z, input q16_type w,
                                     input q16_type rx, input q16_type ry, input q16_type rz,
                                     input q16_type rw, input logic ovf);
      add_row(op, 2'd3, 2'd3, Q_MIN, x, y, z, w);
      directed_rows[$].typed = 1'b1;
      directed_rows[$].want.res[0] = rx;
      directed_rows[$].want.res[1] = ry;
      directed_rows[$].want.res[2] = rz;
      directed_rows[$].want.res[3] = rw;
      directed_rows[$].want.overflow = ovf;
   endfunction

   // Mostly small values so that sums stay in range; some full-width and extremes.
   function automatic q16_type rand_q16();
      case ($urandom_range(0, 7))
         0, 1: return q16_type'($urandom);
         2: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
         3: return q16_type'($urandom_range(0, 131071)) - 32'sd65536;
         default: return q16_type'($urandom_range(0, 1048575)) - 32'sd524288;
      endcase
   endfunction

   function automatic stim_row_type random_request();
      stim_row_type s;
      int pick, k;
      pick = $urandom_range(0, 99);
      if (pick < 30)      s.op = mvt_pkg::OP_WRITE;
      else if (pick < 36) s.op = mvt_pkg::OP_TRANSPOSE;
      else if (pick < 68) s.op = mvt_pkg::OP_MAT_VEC;
      else                s.op = mvt_pkg::OP_VEC_MAT;
      s.row = mvt_pkg::IDX_W'($urandom);
      s.col = mvt_pkg::IDX_W'($urandom);
      s.value = rand_q16();
      for (k = 0; k < mvt_pkg::N_CELLS; k++)
         s.vec[k] = rand_q16();
      s.typed = 1'b0;
      return s;
   endfunction

   task automatic send_request(input stim_row_type s, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation <= s.op;
      req_row       <= s.row;
      req_col       <= s.col;
      req_value     <= s.value;
      req_vec_x     <= s.vec[0];
      req_vec_y     <= s.vec[1];
      req_vec_z     <= s.vec[2];
      req_vec_w     <= s.vec[3];
      req_valid     <= 1'b1;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      apply_request(s);
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] MISMATCH response %0d: %s", $realtime, results_seen, msg);
   endtask

   task automatic check_response();
      transform_result_type want;
      q16_type got [mvt_pkg::N_CELLS];
      int i;
      got[0] = rsp_res_x;
      got[1] = rsp_res_y;
      got[2] = rsp_res_z;
      got[3] = rsp_res_w;
      if (pending_transforms.size() == 0) begin
         report_mismatch("response with no transform pending");
      end else begin
         want = pending_transforms.pop_front();
         for (i = 0; i < mvt_pkg::N_CELLS; i++)
            if (got[i] !== want.res[i])
               report_mismatch($sformatf("component %0d got %h want %h", i, got[i],
                                         want.res[i]));
         if (rsp_overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %b want %b", rsp_overflow,
                                      want.overflow));
         if (want.overflow)
            n_saturated++;
      end
   endtask

   // Response side: random stalls, calm stretches, and one long hold-off.
   initial begin
      int stall;
      bit no_stall;
      no_stall = 1'b0;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (results_seen % 40 == 0)
            no_stall = ($urandom_range(0, 3) == 0);
         if (results_seen == HOLD_OFF_AT)
            stall = HOLD_OFF_CYCLES;
         else
            stall = no_stall ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         results_seen++;
         check_response();
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b1 || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no traffic for %0d cycles", $realtime, idle_cycles);
         $display("tb_matrix4x4_vector_transform: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int n, k;
      bit no_gap;
      for (k = 0; k < 16; k++)
         shadow_matrix[k] = '0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= mvt_pkg::OP_WRITE;
      req_row       <= '0;
      req_col       <= '0;
      req_value     <= '0;
      req_vec_x     <= '0;
      req_vec_y     <= '0;
      req_vec_z     <= '0;
      req_vec_w     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero matrix after reset
      add_typed(mvt_pkg::OP_MAT_VEC, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 0, 1'b0);
      add_typed(mvt_pkg::OP_VEC_MAT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 1'b0);
      // saturation both ways through a single extreme element
      add_row(mvt_pkg::OP_WRITE, 2'd0, 2'd0, Q_MAX, ONE, Q_MIN, Q_MAX, -ONE);
      add_typed(mvt_pkg::OP_MAT_VEC, Q_MAX, 0, 0, 0, Q_MAX, 0, 0, 0, 1'b1);
      add_typed(mvt_pkg::OP_MAT_VEC, Q_MIN, 0, 0, 0, Q_MIN, 0, 0, 0, 1'b1);
      add_typed(mvt_pkg::OP_VEC_MAT, Q_MAX, 0, 0, 0, Q_MAX, 0, 0, 0, 1'b1);
      add_row(mvt_pkg::OP_WRITE, 2'd0, 2'd0, Q_MIN, 0, 0, 0, 0);
      add_typed(mvt_pkg::OP_MAT_VEC, Q_MIN, 0, 0, 0, Q_MAX, 0, 0, 0, 1'b1);
      // asymmetric matrix, then transforms around a transpose
      add_row(mvt_pkg::OP_WRITE, 2'd3, 2'd3, Q_MAX, 0, 0, 0, 0);
      add_row(mvt_pkg::OP_WRITE, 2'd0, 2'd3, ONE, 0, 0, 0, 0);
      add_row(mvt_pkg::OP_WRITE, 2'd3, 2'd0, -ONE, 0, 0, 0, 0);
      add_row(mvt_pkg::OP_WRITE, 2'd1, 2'd2, ONE + HALF, 0, 0, 0, 0);
      add_row(mvt_pkg::OP_WRITE, 2'd2, 2'd1, 32'sh1234_5678, Q_MAX, Q_MIN, -1,
              32'sh5A5A_A5A5);
      add_row(mvt_pkg::OP_MAT_VEC, 2'd2, 2'd1, Q_MAX, ONE, 2 * ONE, -ONE - HALF, HALF);
      add_row(mvt_pkg::OP_VEC_MAT, 2'd1, 2'd3, Q_MIN, ONE, 2 * ONE, -ONE - HALF, HALF);
      add_row(mvt_pkg::OP_TRANSPOSE, 2'd3, 2'd2, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
      add_row(mvt_pkg::OP_MAT_VEC, 2'd0, 2'd0, 0, ONE, 2 * ONE, -ONE - HALF, HALF);
      add_row(mvt_pkg::OP_VEC_MAT, 2'd0, 2'd0, 0, ONE, 2 * ONE, -ONE - HALF, HALF);
      // tiny negative products floor toward minus infinity
      add_row(mvt_pkg::OP_MAT_VEC, 2'd0, 2'd0, 0, -1, -1, -1, -1);
      add_row(mvt_pkg::OP_WRITE, 2'd1, 2'd1, 1, 0, 0, 0, 0);
      add_row(mvt_pkg::OP_MAT_VEC, 2'd0, 2'd0, 0, Q_MIN, 1, -1, Q_MAX);
      add_row(mvt_pkg::OP_TRANSPOSE, 2'd0, 2'd0, 0, 0, 0, 0, 0);
      add_row(mvt_pkg::OP_VEC_MAT, 2'd0, 2'd0, 0, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
      add_row(mvt_pkg::OP_WRITE, 2'd2, 2'd2, 0, 0, 0, 0, 0);

      foreach (directed_rows[k])
         send_request(directed_rows[k], 1'b0);

      no_gap = 1'b0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == PAUSE_AT) begin
            // let every response drain before going on
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_transforms.size() != 0) @(posedge clock);
         end
         if (n % 50 == 0)
            no_gap = ($urandom_range(0, 3) == 0);
         send_request(random_request(), no_gap);
      end
      req_valid <= 1'b0;

      while (pending_transforms.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d element writes, %0d transposes, %0d transforms",
               n_writes, n_transposes, n_transforms);
      $display("%0d responses checked, %0d saturated, with a %0d-cycle output hold-off",
               results_seen, n_saturated, HOLD_OFF_CYCLES);
      if (error_count == 0)
         $display("tb_matrix4x4_vector_transform: done, clean");
      else
         $display("tb_matrix4x4_vector_transform: done, errors");
      $finish;
   end

endmodule
